FILE: rtl/core/websocket_frame_deframer_unit_macros.svh
// Assertion helpers for the frame deframer.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define WSFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WSFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/wsfd_pkg.sv
package wsfd_pkg;

   // Parse phases of the receive side
   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT,
      PH_MASK,
      PH_DATA,
      PH_CLOSED
   } phase_type;

   // What to do with payload bytes of the current frame
   typedef enum logic [1:0] {
      ACT_DRAIN,
      ACT_TEXT,
      ACT_PING
   } action_type;

   // Result event codes
   typedef enum logic [2:0] {
      EV_TEXT_BYTE,
      EV_PING_BYTE,
      EV_TEXT_EMPTY,
      EV_PING_EMPTY,
      EV_CLOSE,
      EV_TEXT_LONG,
      EV_PING_LONG
   } event_type;

   localparam int unsigned CAP_W    = 21;
   localparam int unsigned LEN_W    = 64;
   localparam int unsigned EXT_W    = 4;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 21'd4096;
   localparam logic [6:0]       PING_MAX_BYTES = 7'd125;

   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   localparam logic [EXT_W-1:0] EXT16_BYTES = 4'd2;
   localparam logic [EXT_W-1:0] EXT64_BYTES = 4'd8;

endpackage

FILE: rtl/core/websocket_frame_deframer_unit.sv
// WebSocket receive-side frame deframer.
// Input channel req_*: one received byte per beat (req_rx_byte), taken at an
// edge where req_valid is high and req_stall is low. Result channel rsp_*:
// at most one event per input byte (kind, unmasked data byte, last flag).
// Configuration: csr_wr_en writes csr_wr_data into the payload capacity;
// write only while no byte is in flight.
// Results are registered: rsp_* is driven straight from the output register.
// Throughput: one byte per cycle while req_stall is low; header parsing, the 64-bit
// length count and unmasking are all done in the single register stage per byte.
// Stall: the result register is backed by one skid entry, so a byte is still
// taken in the cycle the receiver first stalls; req_stall rises only once the
// skid entry holds a result, and falls the cycle after the receiver drains it.
// Reset (synchronous, active high): parser returns to the first header byte,
// capacity returns to 4096, the result and skid entries are emptied.
// After a close frame every byte is taken and dropped until reset.
`include "websocket_frame_deframer_unit_macros.svh"

module websocket_frame_deframer_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [wsfd_pkg::CAP_W-1:0]  csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_event_kind,
   output logic [7:0]                  rsp_data_byte,
   output logic                        rsp_last_of_frame
);
   import wsfd_pkg::*;

   // Parser state
   logic [CAP_W-1:0] cap_ff, cap_in;
   phase_type        phase_ff, phase_in;
   logic [3:0]       opcode_ff, opcode_in;
   logic             mask_ff, mask_in;
   logic [EXT_W-1:0] ext_left_ff, ext_left_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [7:0]       key_ff [4];
   logic [7:0]       key_in [4];
   logic [1:0]       pos_ff, pos_in;
   action_type       action_ff, action_in;

   // Result and skid entries
   logic             out_valid_ff, out_valid_in;
   event_type        out_kind_ff, out_kind_in;
   logic [7:0]       out_data_ff, out_data_in;
   logic             out_last_ff, out_last_in;
   logic             skid_valid_ff, skid_valid_in;
   event_type        skid_kind_ff, skid_kind_in;
   logic [7:0]       skid_data_ff, skid_data_in;
   logic             skid_last_ff, skid_last_in;

   // Per-beat decode
   logic             accept;
   logic             out_take;
   logic [6:0]       len7;
   logic             len7_ext;
   logic [LEN_W-1:0] len_ext;
   logic [LEN_W-1:0] hdr_len;
   logic             hdr_end;
   logic             len_zero;
   logic             len_ping_long;
   logic             len_text_long;
   logic             hdr_emit;
   event_type        hdr_kind;
   action_type       hdr_action;
   logic             hdr_closed;
   logic [7:0]       unmasked;
   logic             res_valid;
   event_type        res_kind;
   logic [7:0]       res_data;
   logic             res_last;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;

   assign len7     = req_rx_byte[6:0];
   assign len7_ext = (len7 == LEN7_EXT16) || (len7 == LEN7_EXT64);
   assign len_ext  = {rem_ff[LEN_W-9:0], req_rx_byte};
   assign unmasked = req_rx_byte ^ (mask_ff ? key_ff[pos_ff] : 8'h00);

   // Pick the frame length as it stands when the header completes
   always_comb begin
      case (phase_ff)
         PH_HDR1: hdr_len = {{(LEN_W-7){1'b0}}, len7};
         PH_EXT:  hdr_len = len_ext;
         default: hdr_len = rem_ff;
      endcase
   end

   // Flag the byte that finishes the header
   always_comb begin
      case (phase_ff)
         PH_HDR1: hdr_end = !len7_ext && !req_rx_byte[7];
         PH_EXT:  hdr_end = (ext_left_ff == EXT_W'(1)) && !mask_ff;
         PH_MASK: hdr_end = (pos_ff == 2'd3);
         default: hdr_end = 1'b0;
      endcase
   end

   assign len_zero      = (hdr_len == '0);
   assign len_ping_long = (|hdr_len[LEN_W-1:7]) || (hdr_len[6:0] > PING_MAX_BYTES);
   assign len_text_long = (hdr_len >= {{(LEN_W-CAP_W){1'b0}}, cap_ff});

   // Decide the payload handling from opcode and length
   always_comb begin
      hdr_emit   = 1'b0;
      hdr_kind   = EV_CLOSE;
      hdr_action = ACT_DRAIN;
      hdr_closed = 1'b0;
      case (opcode_ff)
         OP_CLOSE: begin
            hdr_emit   = 1'b1;
            hdr_closed = 1'b1;
         end
         OP_PING: begin
            if (len_ping_long) begin
               hdr_emit = 1'b1;
               hdr_kind = EV_PING_LONG;
            end else if (len_zero) begin
               hdr_emit = 1'b1;
               hdr_kind = EV_PING_EMPTY;
            end else begin
               hdr_action = ACT_PING;
            end
         end
         OP_CONT, OP_TEXT: begin
            if (len_text_long) begin
               hdr_emit = 1'b1;
               hdr_kind = EV_TEXT_LONG;
            end else if (len_zero) begin
               hdr_emit = 1'b1;
               hdr_kind = EV_TEXT_EMPTY;
            end else begin
               hdr_action = ACT_TEXT;
            end
         end
         default: begin
            hdr_action = ACT_DRAIN;
         end
      endcase
   end

   // Next parser state
   always_comb begin
      phase_in    = phase_ff;
      opcode_in   = opcode_ff;
      mask_in     = mask_ff;
      ext_left_in = ext_left_ff;
      rem_in      = rem_ff;
      key_in      = key_ff;
      pos_in      = pos_ff;
      action_in   = action_ff;
      if (accept) begin
         case (phase_ff)
            PH_HDR0: begin
               opcode_in = req_rx_byte[3:0];
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               mask_in = req_rx_byte[7];
               rem_in  = '0;
               if (len7 == LEN7_EXT16) begin
                  ext_left_in = EXT16_BYTES;
                  phase_in    = PH_EXT;
               end else if (len7 == LEN7_EXT64) begin
                  ext_left_in = EXT64_BYTES;
                  phase_in    = PH_EXT;
               end else begin
                  rem_in      = {{(LEN_W-7){1'b0}}, len7};
                  ext_left_in = '0;
                  if (req_rx_byte[7]) begin
                     pos_in   = 2'd0;
                     phase_in = PH_MASK;
                  end
               end
            end
            PH_EXT: begin
               rem_in      = len_ext;
               ext_left_in = ext_left_ff - EXT_W'(1);
               if ((ext_left_ff == EXT_W'(1)) && mask_ff) begin
                  pos_in   = 2'd0;
                  phase_in = PH_MASK;
               end
            end
            PH_MASK: begin
               key_in[pos_ff] = req_rx_byte;
               pos_in         = pos_ff + 2'd1;
            end
            PH_DATA: begin
               pos_in = pos_ff + 2'd1;
               rem_in = rem_ff - LEN_W'(1);
               if (rem_ff == LEN_W'(1)) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         // Header complete: set up the payload
         if (hdr_end) begin
            pos_in    = 2'd0;
            action_in = hdr_action;
            if (hdr_closed) begin
               phase_in = PH_CLOSED;
            end else if (len_zero) begin
               phase_in = PH_HDR0;
            end else begin
               phase_in = PH_DATA;
            end
         end
      end
   end

   // Result of the current beat
   always_comb begin
      res_valid = 1'b0;
      res_kind  = EV_TEXT_BYTE;
      res_data  = 8'h00;
      res_last  = 1'b1;
      if (accept && hdr_end) begin
         res_valid = hdr_emit;
         res_kind  = hdr_kind;
      end else if (accept && (phase_ff == PH_DATA)) begin
         res_last = (rem_ff == LEN_W'(1));
         case (action_ff)
            ACT_TEXT: begin
               res_valid = 1'b1;
               res_kind  = EV_TEXT_BYTE;
               res_data  = unmasked;
            end
            ACT_PING: begin
               res_valid = 1'b1;
               res_kind  = EV_PING_BYTE;
               res_data  = unmasked;
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   // Steer results into the output register or the skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_kind_in   = out_kind_ff;
      out_data_in   = out_data_ff;
      out_last_in   = out_last_ff;
      skid_valid_in = skid_valid_ff;
      skid_kind_in  = skid_kind_ff;
      skid_data_in  = skid_data_ff;
      skid_last_in  = skid_last_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_valid_in  = 1'b1;
            out_kind_in   = skid_kind_ff;
            out_data_in   = skid_data_ff;
            out_last_in   = skid_last_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_in = res_valid;
         out_kind_in  = res_kind;
         out_data_in  = res_data;
         out_last_in  = res_last;
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_kind_in  = res_kind;
         skid_data_in  = res_data;
         skid_last_in  = res_last;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CAPACITY_RESET;
         phase_ff      <= PH_HDR0;
         opcode_ff     <= '0;
         mask_ff       <= 1'b0;
         ext_left_ff   <= '0;
         rem_ff        <= '0;
         key_ff        <= '{default: 8'h00};
         pos_ff        <= 2'd0;
         action_ff     <= ACT_DRAIN;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         phase_ff      <= phase_in;
         opcode_ff     <= opcode_in;
         mask_ff       <= mask_in;
         ext_left_ff   <= ext_left_in;
         rem_ff        <= rem_in;
         key_ff        <= key_in;
         pos_ff        <= pos_in;
         action_ff     <= action_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      out_kind_ff  <= out_kind_in;
      out_data_ff  <= out_data_in;
      out_last_ff  <= out_last_in;
      skid_kind_ff <= skid_kind_in;
      skid_data_ff <= skid_data_in;
      skid_last_ff <= skid_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_kind    = out_kind_ff;
   assign rsp_data_byte     = out_data_ff;
   assign rsp_last_of_frame = out_last_ff;

   // Checks
   `WSFD_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid entry full while output register empty")
   `WSFD_ASSERT_NEXT(a_closed_sticky, clock, reset, phase_ff == PH_CLOSED, phase_ff == PH_CLOSED, "parser left the closed phase")
   `WSFD_ASSERT_NEXT(a_text_byte_kept, clock, reset, accept && (phase_ff == PH_DATA) && (action_ff == ACT_TEXT), out_valid_ff, "text payload beat produced no result")
   `WSFD_ASSERT_NOW(a_event_no_data, clock, reset, out_valid_ff && (out_kind_ff != EV_TEXT_BYTE) && (out_kind_ff != EV_PING_BYTE), (out_data_ff == 8'h00) && out_last_ff, "frame event carries data or lacks last flag")

endmodule

FILE: sim/websocket_frame_deframer_unit_checker.sv
module websocket_frame_deframer_unit_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [wsfd_pkg::CAP_W-1:0] csr_wr_data,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [7:0]                 req_rx_byte,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [2:0]                 rsp_event_kind,
   input  logic [7:0]                 rsp_data_byte,
   input  logic                       rsp_last_of_frame,
   output int unsigned                mismatch_count,
   output int unsigned                events_pending
);
   import wsfd_pkg::*;

   typedef struct packed {
      event_type  kind;
      logic [7:0] data_byte;
      logic       last_of_frame;
   } deframe_event_type;

   // Shadow parser state
   phase_type        phase;
   action_type       action;
   logic [3:0]       opcode;
   logic             masked;
   logic [EXT_W-1:0] ext_left;
   logic [LEN_W-1:0] remaining;
   logic [7:0]       mask_key [4];
   logic [1:0]       key_pos;
   logic [CAP_W-1:0] capacity;

   deframe_event_type expected_events [$];

   task automatic report_mismatch(input string what);
      $display("[%0t] deframer mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic push_event(input event_type kind, input logic [7:0] data,
                             input logic last);
      deframe_event_type ev;
      ev.kind = kind;
      ev.data_byte = data;
      ev.last_of_frame = last;
      expected_events.push_back(ev);
   endtask

   // Header complete: pick what the payload turns into
   task automatic close_header();
      key_pos = '0;
      action = ACT_DRAIN;
      if (opcode == OP_CLOSE) begin
         phase = PH_CLOSED;
         push_event(EV_CLOSE, 8'h00, 1'b1);
      end else begin
         if (opcode == OP_PING) begin
            if (remaining > LEN_W'(PING_MAX_BYTES)) begin
               push_event(EV_PING_LONG, 8'h00, 1'b1);
            end else if (remaining == '0) begin
               push_event(EV_PING_EMPTY, 8'h00, 1'b1);
            end else begin
               action = ACT_PING;
            end
         end else if (opcode == OP_TEXT || opcode == OP_CONT) begin
            // size check wins over the empty check
            if (remaining >= LEN_W'(capacity)) begin
               push_event(EV_TEXT_LONG, 8'h00, 1'b1);
            end else if (remaining == '0) begin
               push_event(EV_TEXT_EMPTY, 8'h00, 1'b1);
            end else begin
               action = ACT_TEXT;
            end
         end
         phase = (remaining == '0) ? PH_HDR0 : PH_DATA;
      end
   endtask

   task automatic close_length();
      if (masked) begin
         key_pos = '0;
         phase = PH_MASK;
      end else begin
         close_header();
      end
   endtask

   // Advance the shadow parser by one received beat
   task automatic take_byte(input logic [7:0] b);
      logic [7:0] d;
      logic       last;
      case (phase)
         PH_HDR0: begin
            opcode = b[3:0];
            phase = PH_HDR1;
         end
         PH_HDR1: begin
            masked = b[7];
            remaining = '0;
            if (b[6:0] == LEN7_EXT16) begin
               ext_left = EXT16_BYTES;
               phase = PH_EXT;
            end else if (b[6:0] == LEN7_EXT64) begin
               ext_left = EXT64_BYTES;
               phase = PH_EXT;
            end else begin
               remaining = LEN_W'(b[6:0]);
               ext_left = '0;
               close_length();
            end
         end
         PH_EXT: begin
            remaining = {remaining[LEN_W-9:0], b};
            ext_left = ext_left - EXT_W'(1);
            if (ext_left == '0) close_length();
         end
         PH_MASK: begin
            mask_key[key_pos] = b;
            key_pos = key_pos + 2'd1;
            if (key_pos == '0) close_header();
         end
         PH_DATA: begin
            d = masked ? (b ^ mask_key[key_pos]) : b;
            key_pos = key_pos + 2'd1;
            remaining = remaining - LEN_W'(1);
            last = (remaining == '0);
            if (last) phase = PH_HDR0;
            if (action == ACT_TEXT) begin
               push_event(EV_TEXT_BYTE, d, last);
            end else if (action == ACT_PING) begin
               push_event(EV_PING_BYTE, d, last);
            end
         end
         default: ;
      endcase
   endtask

   // Compare one accepted result beat with the oldest expectation
   task automatic check_result();
      deframe_event_type ev;
      if (expected_events.size() == 0) begin
         report_mismatch($sformatf("unexpected result kind %0d data %02h last %0b",
                                   rsp_event_kind, rsp_data_byte, rsp_last_of_frame));
      end else begin
         ev = expected_events.pop_front();
         if (rsp_event_kind !== ev.kind) begin
            report_mismatch($sformatf("event_kind %0d, expected %0d",
                                      rsp_event_kind, ev.kind));
         end
         if (rsp_data_byte !== ev.data_byte) begin
            report_mismatch($sformatf("data_byte %02h, expected %02h",
                                      rsp_data_byte, ev.data_byte));
         end
         if (rsp_last_of_frame !== ev.last_of_frame) begin
            report_mismatch($sformatf("last_of_frame %0b, expected %0b",
                                      rsp_last_of_frame, ev.last_of_frame));
         end
      end
   endtask

   // Sample both channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         phase = PH_HDR0;
         action = ACT_DRAIN;
         opcode = '0;
         masked = 1'b0;
         ext_left = '0;
         remaining = '0;
         for (int i = 0; i < 4; i++) mask_key[i] = 8'h00;
         key_pos = '0;
         capacity = CAPACITY_RESET;
         expected_events.delete();
      end else begin
         if (csr_wr_en) capacity = csr_wr_data;
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) take_byte(req_rx_byte);
      end
      events_pending = expected_events.size();
   end

endmodule

FILE: sim/websocket_frame_deframer_unit_tb.sv
module websocket_frame_deframer_unit_tb;
   import wsfd_pkg::*;

   localparam int unsigned SILENT_LIMIT = 2000;
   localparam int unsigned PHASE_BYTES  = 50;
   localparam logic [3:0]  OP_PONG      = 4'hA;
   localparam logic [3:0]  OP_RSV_CTRL  = 4'hF;

   typedef enum logic [1:0] {
      LEN_SHORT,
      LEN_EXT16,
      LEN_EXT64
   } len_form_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [7:0]       req_rx_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [2:0]       rsp_event_kind;
   logic [7:0]       rsp_data_byte;
   logic             rsp_last_of_frame;

   int unsigned      mismatch_count;
   int unsigned      events_pending;
   int unsigned      send_idle_pct = 0;
   int unsigned      recv_idle_pct = 0;
   int unsigned      bytes_sent = 0;
   int unsigned      silent_cycles = 0;
   logic [CAP_W-1:0] capacity_now = CAPACITY_RESET;

   websocket_frame_deframer_unit uut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   websocket_frame_deframer_unit_checker deframe_check (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .mismatch_count    (mismatch_count),
      .events_pending    (events_pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // End the run if no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         silent_cycles <= 0;
      end else begin
         silent_cycles <= silent_cycles + 1;
         if (silent_cycles >= SILENT_LIMIT) begin
            $display("websocket_frame_deframer_unit_tb NOT OK");
            $finish;
         end
      end
   end

   // Present one byte, idling first at random, and hold it until taken
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_rx_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   // Drop valid and wait until every result is out and the pipe is empty
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (events_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capacity_now = value;
   endtask

   task automatic send_header(input logic [3:0] opcode, input logic [63:0] length,
                              input len_form_type form, input logic masked,
                              input logic [31:0] key);
      logic [3:0] flags;
      logic [6:0] len7;
      flags = 4'($urandom);
      send_byte({flags, opcode});
      case (form)
         LEN_SHORT: len7 = length[6:0];
         LEN_EXT16: len7 = LEN7_EXT16;
         default:   len7 = LEN7_EXT64;
      endcase
      send_byte({masked, len7});
      if (form == LEN_EXT16) begin
         send_byte(length[15:8]);
         send_byte(length[7:0]);
      end else if (form == LEN_EXT64) begin
         for (int i = 7; i >= 0; i--) send_byte(length[8*i +: 8]);
      end
      if (masked) begin
         for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
      end
   endtask

   task automatic send_payload(input logic [63:0] count);
      logic [63:0] n;
      for (n = 0; n < count; n++) send_byte(8'($urandom));
   endtask

   // Mostly minimal encodings, some padded ones
   function automatic len_form_type pick_form(input logic [63:0] length);
      int unsigned r;
      r = $urandom_range(9);
      if (length > 64'd65535) return LEN_EXT64;
      if (length > 64'd125) return (r < 5) ? LEN_EXT16 : LEN_EXT64;
      if (r < 7) return LEN_SHORT;
      return (r == 7) ? LEN_EXT16 : LEN_EXT64;
   endfunction

   // Pong, binary, reserved data and reserved control opcodes
   function automatic logic [3:0] drained_opcode();
      logic [3:0] op;
      do op = 4'($urandom);
      while (op == OP_CONT || op == OP_TEXT || op == OP_CLOSE || op == OP_PING);
      return op;
   endfunction

   task automatic random_frame();
      int unsigned pick;
      logic [3:0]  opcode;
      logic [63:0] length;
      pick = $urandom_range(99);
      if (pick < 45) begin
         opcode = $urandom_range(1) ? OP_TEXT : OP_CONT;
         length = ($urandom_range(7) == 0) ? 64'($urandom_range(60)) :
                                             64'($urandom_range(12));
      end else if (pick < 60) begin
         // land on either side of the capacity bound when it is 64 or less
         opcode = $urandom_range(1) ? OP_TEXT : OP_CONT;
         if (capacity_now <= 64) begin
            length = 64'(capacity_now) + 64'($urandom_range(2));
            if (length != 0) length = length - 1;
         end else begin
            length = 64'($urandom_range(12));
         end
      end else if (pick < 80) begin
         opcode = OP_PING;
         length = ($urandom_range(9) == 0) ? 64'($urandom_range(131, 120)) :
                                             64'($urandom_range(8));
      end else begin
         opcode = drained_opcode();
         length = 64'($urandom_range(10));
      end
      send_header(opcode, length, pick_form(length), 1'($urandom), $urandom);
      send_payload(length);
   endtask

   task automatic random_phase();
      int unsigned stop_at;
      stop_at = bytes_sent + PHASE_BYTES;
      while (bytes_sent < stop_at) random_frame();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames at the reset capacity, then at capacities 1 and 0
      send_idle_pct = 30;
      recv_idle_pct = 72;
      send_header(OP_TEXT, 64'd2, LEN_SHORT, 1'b0, 32'h0);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_header(OP_CONT, 64'd1, LEN_SHORT, 1'b1, 32'hFFFF_FFFF);
      send_byte(8'hFF);
      send_header(OP_CONT, 64'd0, LEN_SHORT, 1'b1, $urandom);
      send_header(OP_PING, 64'd1, LEN_SHORT, 1'b0, 32'h0);
      send_byte(8'h5A);
      send_header(OP_PING, 64'd0, LEN_SHORT, 1'b0, 32'h0);
      send_header(OP_RSV_CTRL, 64'd0, LEN_SHORT, 1'b0, 32'h0);
      settle();
      write_capacity(21'd1);
      send_header(OP_TEXT, 64'd1, LEN_SHORT, 1'b0, 32'h0);
      send_byte(8'hA5);
      settle();
      write_capacity(21'd0);
      send_header(OP_TEXT, 64'd0, LEN_SHORT, 1'b0, 32'h0);

      // Sender idles less than the receiver stalls
      settle();
      write_capacity(CAP_W'($urandom_range(40, 1)));
      random_phase();

      // Receiver stalls less than the sender idles
      settle();
      write_capacity(21'd1048576);
      send_idle_pct = 72;
      recv_idle_pct = 30;
      send_header(OP_PING, 64'd125, LEN_SHORT, 1'b1, $urandom);
      send_payload(64'd125);
      send_header(OP_PING, 64'd126, LEN_EXT16, 1'b0, 32'h0);
      send_payload(64'd126);
      send_header(OP_PONG, 64'd3, LEN_SHORT, 1'b1, $urandom);
      send_payload(64'd3);
      random_phase();

      // Full rate on both sides
      settle();
      write_capacity(CAP_W'($urandom_range(30)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase();

      // One text frame at the widest capacity, 64-bit length form
      settle();
      write_capacity(21'h1FFFFF);
      send_header(OP_TEXT, 64'd20, LEN_EXT64, 1'b1, $urandom);
      send_payload(64'd20);

      // Close with the widest length; everything after it is dropped
      send_header(OP_CLOSE, 64'hFFFF_FFFF_FFFF_FFFF, LEN_EXT64, 1'b1, $urandom);
      send_header(OP_TEXT, 64'd2, LEN_SHORT, 1'b0, 32'h0);
      send_payload(64'd14);

      req_valid <= 1'b0;
      do @(negedge clock); while (events_pending != 0);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("websocket_frame_deframer_unit_tb OK");
      end else begin
         $display("websocket_frame_deframer_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
